// ----- rtl/tll_pkg.sv -----
// shared constants, types and helpers for the thermistor table linearizer
package tll_pkg;

  localparam int SENSORS = 8;
  localparam int ENTRIES = 64;

  localparam int SEN_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int LEN_W  = $clog2(ENTRIES + 1);
  localparam int ADDR_W = (SENSORS * ENTRIES > 1) ? $clog2(SENSORS * ENTRIES) : 1;

  localparam int RAW_W  = 16;
  localparam int CEL_W  = 16;
  localparam int WORD_W = RAW_W + CEL_W;
  localparam int FRAC_W = 8;
  localparam int TEMP_W = CEL_W + FRAC_W;
  localparam int CFG_W  = 4;

  // interpolation datapath widths
  localparam int P0_W   = CEL_W + RAW_W + 1;
  localparam int P1_W   = 2 * (RAW_W + 1);
  localparam int SUM_W  = P1_W + 1;
  localparam int DSOR_W = RAW_W;
  localparam int Q_W    = TEMP_W;
  localparam int DEND_W = Q_W + DSOR_W;

  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_LOAD    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_SENSOR = 2'd1,
    STATUS_EMPTY      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_RD_LO,
    ST_RD_HI,
    ST_EDGE,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef logic [3:0]              sensor_t;
  typedef logic [RAW_W-1:0]        raw_t;
  typedef logic [5:0]              entry_idx_t;
  typedef logic signed [CEL_W-1:0] degrees_t;
  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [CFG_W-1:0]        cfg_data_t;

  // first table word of a sensor
  function automatic logic [ADDR_W-1:0] tbl_base(input sensor_t s);
    return ADDR_W'(32'(s) * ENTRIES);
  endfunction

endpackage

// ----- rtl/tll_channels.sv -----
// handshake channels: input items, result items and the configuration write

interface tll_req_if;
  import tll_pkg::*;
  logic       valid;
  logic       ready;
  op_t        operation;
  sensor_t    sensor;
  raw_t       raw_reading;
  entry_idx_t entry_index;
  degrees_t   entry_celsius;
  logic       last_entry;

  modport source (output valid, operation, sensor, raw_reading, entry_index,
                  entry_celsius, last_entry, input ready);
  modport sink   (input valid, operation, sensor, raw_reading, entry_index,
                  entry_celsius, last_entry, output ready);
endinterface

interface tll_rsp_if;
  import tll_pkg::*;
  logic    valid;
  logic    ready;
  temp_t   temperature;
  status_t status;

  modport source (output valid, temperature, status, input ready);
  modport sink   (input valid, temperature, status, output ready);
endinterface

interface tll_cfg_if;
  import tll_pkg::*;
  logic      valid;
  logic      ready;
  cfg_data_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/thermistor_table_linearizer_top.sv -----
// thermistor table linearizer: table store, bisection sequencer and interpolation
//
//   channel  dir   payload                                           handshake
//   req      in    operation sensor raw_reading entry_index          valid/ready
//                  entry_celsius last_entry
//   rsp      out   temperature status                                valid/ready
//   cfg      in    data (sensors_in_use)                             valid/ready
//
// load: written straight into the table. convert: bisection steps (up to log2(length)+1
// steps), then multiply, sum and the one-bit divider; clamped readings go from the last
// step through the edge state, and errors go straight to the result.
// rst is synchronous: table lengths clear to zero, sensors_in_use to one, table words stay.
// a result waits in the output register while the next item is taken; a second result
// holds in the sequencer, and the input with it, until rsp is ready.
module thermistor_table_linearizer_top (
  input logic      clk,
  input logic      rst,
  tll_req_if.sink  req,
  tll_rsp_if.source rsp,
  tll_cfg_if.sink  cfg
);
  import tll_pkg::*;

  state_t state, state_next;

  cfg_data_t        sensors_in_use;
  logic [LEN_W-1:0] tbl_len [SENSORS];

  logic [ADDR_W-1:0] base;
  logic [LEN_W-1:0]  len, lo_idx, hi_idx, mid;
  raw_t              raw;
  logic [WORD_W-1:0] lo_word, hi_word;
  logic signed [P0_W-1:0] p0;
  logic signed [P1_W-1:0] p1;
  logic [DSOR_W-1:0] den;
  logic              neg;
  temp_t             res_temp;
  status_t           res_status;
  logic              out_valid;
  temp_t             out_temp;
  status_t           out_status;

  // ram port
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;

  // divider port
  logic              div_start;
  logic              div_done;
  logic [DEND_W-1:0] dividend;
  logic [Q_W-1:0]    quotient;

  // fsm outputs
  logic req_ready;
  logic load_out;

  // decode of the item at the input
  logic             req_fire;
  logic             is_load;
  logic             load_ok;
  logic             bad_sensor;
  logic [LEN_W-1:0] sel_len;
  logic             empty;

  // bisection and interpolation terms
  logic [LEN_W-1:0]       mid_c;
  logic                   at_first;
  logic                   at_end;
  raw_t                   v00, v10;
  logic                   go_left, go_right, flat;
  raw_t                   den_c, diff_c;
  logic signed [CEL_W:0]  dt_c;
  logic signed [P0_W-1:0] p0_c;
  logic signed [P1_W-1:0] p1_c;
  logic signed [SUM_W-1:0] sum_c;
  logic [SUM_W-1:0]       mag_c;
  temp_t                  q_signed;

  assign req_fire = req.valid && req_ready;
  assign is_load  = (req.operation == OP_LOAD);
  assign load_ok  = (32'(req.sensor) < SENSORS) && (32'(req.entry_index) < ENTRIES);

  assign bad_sensor = (32'(req.sensor) >= 32'(sensors_in_use)) ||
                      (32'(req.sensor) >= SENSORS);
  assign sel_len    = bad_sensor ? '0 : tbl_len[req.sensor[SEN_W-1:0]];
  assign empty      = (sel_len == '0) || (32'(sel_len) > ENTRIES);

  assign mid_c    = LEN_W'(({1'b0, lo_idx} + {1'b0, hi_idx}) >> 1);
  assign at_first = (mid_c == '0);
  assign at_end   = (mid_c == lo_idx) || (mid_c == hi_idx);

  assign v00      = lo_word[RAW_W-1:0];
  assign v10      = rd_data[RAW_W-1:0];
  assign go_left  = raw < v00;
  assign go_right = raw > v10;
  assign flat     = (v10 == v00);

  // segment terms, from the two registered words
  assign den_c  = hi_word[RAW_W-1:0] - lo_word[RAW_W-1:0];
  assign diff_c = raw - lo_word[RAW_W-1:0];
  assign dt_c   = $signed({hi_word[WORD_W-1], hi_word[WORD_W-1:RAW_W]}) -
                  $signed({lo_word[WORD_W-1], lo_word[WORD_W-1:RAW_W]});
  assign p0_c   = $signed(lo_word[WORD_W-1:RAW_W]) * $signed({1'b0, den_c});
  assign p1_c   = $signed({1'b0, diff_c}) * dt_c;

  // t0*den + diff*(t1-t0); the Q8 scale is applied as a shift into the divider
  // the magnitude stays below 2^31, so the top sum bits drop out
  assign sum_c    = SUM_W'(p0) + SUM_W'(p1);
  assign mag_c    = sum_c[SUM_W-1] ? SUM_W'(-sum_c) : SUM_W'(sum_c);
  assign dividend = DEND_W'({mag_c, FRAC_W'(0)});
  assign q_signed = neg ? TEMP_W'(-$signed(quotient)) : $signed(quotient);

  // loads write straight through; reads only start once the item is taken,
  // so a read never meets a write of the same cycle
  assign wr_en   = req_fire && is_load && load_ok;
  assign wr_addr = tbl_base(req.sensor) + ADDR_W'(req.entry_index);
  assign wr_data = {req.entry_celsius, req.raw_reading};

  tll_ram #(
    .DEPTH (SENSORS * ENTRIES),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tll_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire && !is_load) begin
          if (bad_sensor || empty) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (at_first || at_end) begin
          state_next = ST_EDGE;
        end else begin
          state_next = ST_RD_LO;
        end
      end
      ST_RD_LO: state_next = ST_RD_HI;
      ST_RD_HI: begin
        if (go_left || go_right) begin
          state_next = ST_STEP;
        end else if (flat) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_EDGE: state_next = ST_DONE;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    req_ready = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    rd_addr   = base;
    case (state)
      ST_IDLE: req_ready = 1'b1;
      ST_STEP: begin
        if (at_first) begin
          rd_addr = base;
        end else if (at_end) begin
          rd_addr = base + ADDR_W'(len - 1'b1);
        end else begin
          rd_addr = base + ADDR_W'(mid_c - 1'b1);
        end
      end
      ST_RD_LO: rd_addr = base + ADDR_W'(mid);
      ST_SUM:   div_start = 1'b1;
      ST_DONE:  load_out = !out_valid || rsp.ready;
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensors_in_use <= CFG_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      sensors_in_use <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SENSORS; i++) begin
        tbl_len[i] <= '0;
      end
    end else if (wr_en && req.last_entry) begin
      tbl_len[req.sensor[SEN_W-1:0]] <= LEN_W'(32'(req.entry_index) + 1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_fire && !is_load) begin
          raw    <= req.raw_reading;
          base   <= tbl_base(req.sensor);
          len    <= sel_len;
          lo_idx <= '0;
          hi_idx <= sel_len;
          res_temp <= '0;
          if (bad_sensor) begin
            res_status <= STATUS_BAD_SENSOR;
          end else begin
            res_status <= STATUS_EMPTY;
          end
        end
      end
      ST_STEP:  mid <= mid_c;
      ST_RD_LO: lo_word <= rd_data;
      ST_RD_HI: begin
        hi_word <= rd_data;
        if (go_left) begin
          hi_idx <= mid;
        end else if (go_right) begin
          lo_idx <= mid;
        end else if (flat) begin
          res_temp   <= {lo_word[WORD_W-1:RAW_W], FRAC_W'(0)};
          res_status <= STATUS_OK;
        end
      end
      // clamped to the first or last entry
      ST_EDGE: begin
        res_temp   <= {rd_data[WORD_W-1:RAW_W], FRAC_W'(0)};
        res_status <= STATUS_OK;
      end
      ST_MUL: begin
        p0  <= p0_c;
        p1  <= p1_c;
        den <= den_c;
      end
      ST_SUM: neg <= sum_c[SUM_W-1];
      ST_DIV: begin
        if (div_done) begin
          res_temp   <= q_signed;
          res_status <= STATUS_OK;
        end
      end
      default: begin
        mid <= mid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_temp   <= res_temp;
      out_status <= res_status;
    end
  end

  assign req.ready       = req_ready;
  assign cfg.ready       = 1'b1;
  assign rsp.valid       = out_valid;
  assign rsp.temperature = out_temp;
  assign rsp.status      = out_status;

endmodule

// ----- rtl/tll_ram.sv -----
// simple dual-port synchronous ram, one write and one registered read port
module tll_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/tll_div.sv -----
// restoring divider, one quotient bit per cycle, quotient known to fit Q_W bits
module tll_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tll_pkg::DEND_W-1:0] dividend,
  input  logic [tll_pkg::DSOR_W-1:0] divisor,
  output logic                      done,
  output logic [tll_pkg::Q_W-1:0]   quotient
);
  import tll_pkg::*;

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DSOR_W-1:0] rem, rem_next;
  logic [Q_W-1:0]    quo, quo_next;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DSOR_W:0]   trial;

  always_comb begin
    trial = {rem, quo[Q_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = DSOR_W'(trial - {1'b0, divisor});
      quo_next = {quo[Q_W-2:0], 1'b1};
    end else begin
      rem_next = DSOR_W'(trial);
      quo_next = {quo[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // high dividend bits start as the partial remainder, already below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[Q_W+DSOR_W-1:Q_W];
      quo <= dividend[Q_W-1:0];
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule
